[design/ckeng_pkg.sv]
`timescale 1ns / 1ps

package ckeng_pkg;

  localparam int unsigned ADDR_START = 12;
  localparam int unsigned ADDR_END   = 20;
  localparam int unsigned CSUM_FIELD = 16;
  localparam int unsigned HDR_CSUM_HI = 10;
  localparam int unsigned HDR_CSUM_LO = 11;
  localparam int unsigned OFF_VER_IHL = 0;
  localparam int unsigned OFF_LEN_HI  = 2;
  localparam int unsigned OFF_LEN_LO  = 3;
  localparam int unsigned OFF_PROTO   = 9;

  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QAW      = $clog2(QDEPTH);
  localparam int unsigned RESDEPTH = 2;
  localparam int unsigned RESAW    = $clog2(RESDEPTH);

  localparam logic [15:0] OFF_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] ip_header_sum;
    logic [15:0] tcp_sum;
    logic        tcp_match;
    logic        length_error;
  } out_item_t;

  // One classified byte: contributions to both sums, plus end-of-packet data.
  typedef struct packed {
    logic [15:0] hdr_word;
    logic [16:0] seg_word;
    logic [16:0] extra;
    logic [15:0] rx_sum;
    logic        err;
    logic        last;
  } cls_t;

endpackage

[design/ckeng_queue.sv]
`timescale 1ns / 1ps

module ckeng_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  ckeng_pkg::cls_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output ckeng_pkg::cls_t rdata_o,
  output logic            empty_o
);
  import ckeng_pkg::*;

  cls_t            mem_q [QDEPTH];
  logic [QAW-1:0]  wptr_q, wptr_d;
  logic [QAW-1:0]  rptr_q, rptr_d;
  logic [QAW:0]    cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_comb begin
    wptr_d = do_wr ? wptr_q + QAW'(1) : wptr_q;
    rptr_d = do_rd ? rptr_q + QAW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + (QAW+1)'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[design/ckeng_front.sv]
`timescale 1ns / 1ps

module ckeng_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ckeng_pkg::in_item_t in_item_i,
  output logic                full_o,
  output logic                q_wr_o,
  output ckeng_pkg::cls_t     q_wdata_o,
  input  logic                q_full_i
);
  import ckeng_pkg::*;

  logic [15:0] off_q, off_d;
  logic [5:0]  hdr_q, hdr_d;
  logic [15:0] tot_q, tot_d;
  logic [7:0]  prot_q, prot_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [7:0]  cs_hi_q, cs_hi_d;
  logic [15:0] rx_q, rx_d;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] w;
  logic [15:0] hdr_ext;
  logic [15:0] seg_off;
  logic        take, hdr_add, addr_add, seg_part, cs_hi, cs_lo, seg_add;
  logic [15:0] dlen;

  assign full_o = q_full_i;
  assign accept = push_i && !q_full_i;
  assign q_wr_o = accept;
  assign b      = in_item_i.data_byte;
  assign w      = off_q[0] ? {8'h00, b} : {b, 8'h00};

  always_comb begin
    take     = (off_q < 16'(OFF_LEN_LO + 1)) || (off_q < tot_q);
    hdr_d    = (take && off_q == 16'(OFF_VER_IHL)) ? {b[3:0], 2'b00} : hdr_q;
    len_hi_d = (take && off_q == 16'(OFF_LEN_HI)) ? b : len_hi_q;
    tot_d    = (take && off_q == 16'(OFF_LEN_LO)) ? {len_hi_q, b} : tot_q;
    prot_d   = (take && off_q == 16'(OFF_PROTO)) ? b : prot_q;
    hdr_ext  = {10'd0, hdr_d};
    hdr_add  = take && (off_q < hdr_ext) && (off_q != 16'(HDR_CSUM_HI))
               && (off_q != 16'(HDR_CSUM_LO));
    addr_add = take && (off_q >= 16'(ADDR_START)) && (off_q < 16'(ADDR_END));
    seg_part = take && (off_q >= hdr_ext);
    seg_off  = off_q - hdr_ext;
    cs_hi    = seg_part && (seg_off == 16'(CSUM_FIELD));
    cs_lo    = seg_part && (seg_off == 16'(CSUM_FIELD + 1));
    seg_add  = seg_part && !cs_hi && !cs_lo;
    cs_hi_d  = cs_hi ? b : cs_hi_q;
    rx_d     = cs_lo ? {cs_hi_q, b} : rx_q;
    dlen     = tot_d - hdr_ext;

    q_wdata_o.hdr_word = hdr_add ? w : 16'h0000;
    // address bytes inside a short header count twice, as in the sum
    unique case ({addr_add, seg_add})
      2'b11:   q_wdata_o.seg_word = {w, 1'b0};
      2'b10,
      2'b01:   q_wdata_o.seg_word = {1'b0, w};
      default: q_wdata_o.seg_word = '0;
    endcase
    q_wdata_o.extra  = {9'd0, prot_d} + {1'b0, dlen};
    q_wdata_o.rx_sum = rx_d;
    q_wdata_o.err    = (tot_d <= hdr_ext);
    q_wdata_o.last   = in_item_i.last_byte;

    off_d = (off_q < OFF_MAX) ? off_q + 16'd1 : off_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      hdr_q    <= '0;
      tot_q    <= '0;
      prot_q   <= '0;
      len_hi_q <= '0;
      cs_hi_q  <= '0;
      rx_q     <= '0;
    end else if (accept) begin
      if (in_item_i.last_byte) begin
        // start over for the next packet
        off_q    <= '0;
        hdr_q    <= '0;
        tot_q    <= '0;
        prot_q   <= '0;
        len_hi_q <= '0;
        cs_hi_q  <= '0;
        rx_q     <= '0;
      end else begin
        off_q    <= off_d;
        hdr_q    <= hdr_d;
        tot_q    <= tot_d;
        prot_q   <= prot_d;
        len_hi_q <= len_hi_d;
        cs_hi_q  <= cs_hi_d;
        rx_q     <= rx_d;
      end
    end
  end

endmodule

[design/ckeng_back.sv]
`timescale 1ns / 1ps

module ckeng_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  ckeng_pkg::cls_t      q_rdata_i,
  output logic                 q_rd_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output ckeng_pkg::out_item_t out_item_o
);
  import ckeng_pkg::*;

  logic [21:0]   hacc_q, hacc_d;
  logic [31:0]   sacc_q, sacc_d;
  logic          fin_v_q, fin_v_d;
  logic [21:0]   fin_h_q;
  logic [31:0]   fin_s_q;
  logic [15:0]   fin_rx_q;
  logic          fin_err_q;

  out_item_t     res_mem_q [RESDEPTH];
  logic [RESAW-1:0] res_wptr_q, res_rptr_q;
  logic [RESAW:0]   res_cnt_q, res_cnt_d;
  logic          res_full, res_wr, res_rd;

  logic          fin_rdy, q_pop, load_fin;
  logic [21:0]   h_sum;
  logic [31:0]   s_sum;
  logic [16:0]   hf1, hf2, sf1, sf2;
  logic [15:0]   tcp_c;
  out_item_t     res;

  assign res_full = (res_cnt_q == (RESAW+1)'(RESDEPTH));
  assign empty_o  = (res_cnt_q == '0);
  assign out_item_o = res_mem_q[res_rptr_q];
  assign res_rd   = pop_i && !empty_o;
  assign res_wr   = fin_v_q && !res_full;

  assign fin_rdy  = !fin_v_q || !res_full;
  assign q_pop    = !q_empty_i && (!q_rdata_i.last || fin_rdy);
  assign q_rd_o   = q_pop;
  assign load_fin = q_pop && q_rdata_i.last;

  always_comb begin
    h_sum  = hacc_q + {6'd0, q_rdata_i.hdr_word};
    s_sum  = sacc_q + {15'd0, q_rdata_i.seg_word};
    hacc_d = hacc_q;
    sacc_d = sacc_q;
    if (q_pop) begin
      hacc_d = load_fin ? '0 : h_sum;
      sacc_d = load_fin ? '0 : s_sum;
    end
    fin_v_d = (fin_v_q && res_full) || load_fin;
  end

  // fold carries twice, then complement
  always_comb begin
    hf1   = {1'b0, fin_h_q[15:0]} + {11'd0, fin_h_q[21:16]};
    hf2   = {1'b0, hf1[15:0]} + {16'd0, hf1[16]};
    sf1   = {1'b0, fin_s_q[15:0]} + {1'b0, fin_s_q[31:16]};
    sf2   = {1'b0, sf1[15:0]} + {16'd0, sf1[16]};
    tcp_c = ~sf2[15:0];
    res.ip_header_sum = ~hf2[15:0];
    res.tcp_sum       = fin_err_q ? 16'h0000 : tcp_c;
    res.tcp_match     = !fin_err_q && (tcp_c == fin_rx_q);
    res.length_error  = fin_err_q;
  end

  always_comb begin
    res_cnt_d = res_cnt_q;
    if (res_wr && !res_rd) begin
      res_cnt_d = res_cnt_q + (RESAW+1)'(1);
    end else if (res_rd && !res_wr) begin
      res_cnt_d = res_cnt_q - (RESAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hacc_q     <= '0;
      sacc_q     <= '0;
      fin_v_q    <= 1'b0;
      res_wptr_q <= '0;
      res_rptr_q <= '0;
      res_cnt_q  <= '0;
    end else begin
      hacc_q    <= hacc_d;
      sacc_q    <= sacc_d;
      fin_v_q   <= fin_v_d;
      res_cnt_q <= res_cnt_d;
      if (res_wr) begin
        res_wptr_q <= res_wptr_q + RESAW'(1);
      end
      if (res_rd) begin
        res_rptr_q <= res_rptr_q + RESAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_fin) begin
      fin_h_q   <= h_sum;
      fin_s_q   <= s_sum + {15'd0, q_rdata_i.extra};
      fin_rx_q  <= q_rdata_i.rx_sum;
      fin_err_q <= q_rdata_i.err;
    end
    if (res_wr) begin
      res_mem_q[res_wptr_q] <= res;
    end
  end

  a_res_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= (RESAW+1)'(RESDEPTH))
    else $error("result buffer count overflow");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_v_q && res_full && !res_rd |=> fin_v_q && $stable(fin_s_q) && $stable(fin_h_q))
    else $error("final sums lost while result buffer full");

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fin |=> hacc_q == '0 && sacc_q == '0)
    else $error("accumulators not cleared after end of packet");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_wr && res.length_error |-> res.tcp_sum == 16'h0000 && !res.tcp_match)
    else $error("length error result carries a TCP sum");

endmodule

[design/ipv4_tcp_checksum_engine_core.sv]
`timescale 1ns / 1ps

// Channel   Handshake          Payload                     Transaction when
// input     push_i / full_o    in_item_i  (in_item_t)      push_i && !full_o
// result    pop_i / empty_o    out_item_o (out_item_t)     pop_i && !empty_o
//
// One byte is taken every cycle while full_o is low; bytes flow front -> 4-entry queue -> back.
// A result is built from its last byte by the classify, accumulate and fold steps
// and waits in a 2-entry result buffer.
// full_o rises only when the queue fills, which happens only while the final
// stage holds a result the result buffer cannot take.
// Reset (rst_ni low) clears all packet state and both queues at once.
module ipv4_tcp_checksum_engine_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  ckeng_pkg::in_item_t  in_item_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output ckeng_pkg::out_item_t out_item_o
);
  import ckeng_pkg::*;

  logic q_wr, q_full, q_rd, q_empty;
  cls_t q_wdata, q_rdata;

  ckeng_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .in_item_i (in_item_i),
    .full_o    (full_o),
    .q_wr_o    (q_wr),
    .q_wdata_o (q_wdata),
    .q_full_i  (q_full)
  );

  ckeng_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  ckeng_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_rdata_i  (q_rdata),
    .q_rd_o     (q_rd),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_item_o (out_item_o)
  );

endmodule
